// ===== rtl/kscal_pkg.sv =====
// kscal_pkg: types, constants and key decode for the keypad scan and calibration block
// no dependencies; imported by kscal_core and keypad_scan_calibration_entry_top
`default_nettype none

package kscal_pkg;

    localparam int ZeroW  = 10;
    localparam int HoldW  = 4;
    localparam int ScanW  = 5;
    localparam int ColW   = 3;
    localparam int RowW   = 4;
    localparam int SampW  = 10;
    localparam int KeyW   = 4;
    localparam int ValW   = 14;
    localparam int OffW   = 16;
    localparam int OutOffW = 15;
    localparam int TempW  = 17;

    localparam logic [ZeroW-1:0] ZeroReset     = 10'd94;
    localparam logic [HoldW-1:0] DebounceReset = 4'd10;

    typedef logic [KeyW-1:0] t_key;

    localparam t_key KeyStar = 4'd10;
    localparam t_key KeyHash = 4'd11;
    localparam t_key KeyNone = 4'd12;

    typedef enum logic {
        CfgZero     = 1'b0,
        CfgDebounce = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [OutOffW-1:0] temperature;
        logic signed [OutOffW-1:0] calibration_offset;
        logic [ValW-1:0]           entered_value;
        logic                      capture_active;
        t_key                      key_code;
        logic [ColW-1:0]           column_drive;
    } t_result;

    // first active row wins, bottom row first
    function automatic t_key key_lookup(input logic [RowW-1:0] rows, input logic [1:0] col);
        t_key k;
        k = KeyNone;
        if (rows[3]) begin
            case (col)
                2'd0:    k = KeyStar;
                2'd1:    k = 4'd0;
                default: k = KeyHash;
            endcase
        end else if (rows[2]) begin
            k = t_key'(4'd7 + {2'b00, col});
        end else if (rows[1]) begin
            k = t_key'(4'd4 + {2'b00, col});
        end else if (rows[0]) begin
            k = t_key'(4'd1 + {2'b00, col});
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/keypad_scan_calibration_entry_top.sv =====
// keypad_scan_calibration_entry_top: stream wrapper with input stage, result register, config
// depends on kscal_pkg and kscal_core
//
//  channel   dir  fields
//  s_axis    in   tdata: row_lines[3:0], adc_sample[13:4]
//  m_axis    out  tdata: column_drive, key_code, capture_active, entered_value, offset, temp
//  cfg       in   i_cfg_we, i_cfg_idx (0 zero count, 1 debounce), i_cfg_wdata
//
//  one request per cycle while the result register is empty or being taken; result valid when it frees
//  request is held in an input register, decoded and summed in one pass, then registered
//  both stages advance whenever the result register is empty or being taken
//  reset (synchronous, low) clears scan state and loads zero count 94, debounce 10
`default_nettype none

module keypad_scan_calibration_entry_top #(
    parameter int MAX_DIGITS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // row_lines[3:0], adc_sample[13:4], zero fill
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // column_drive[2:0], key_code[6:3], capture_active[7],
                                        // entered_value[21:8], calibration_offset[36:22],
                                        // temperature[51:37], zero fill
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [9:0]  i_cfg_wdata
);
    import kscal_pkg::*;

    logic                r_s1_valid;
    logic [RowW-1:0]     r_s1_rows;
    logic [SampW-1:0]    r_s1_sample;
    logic                r_out_valid;
    t_result             r_out_data;
    logic [ZeroW-1:0]    r_zero;
    logic [HoldW-1:0]    r_debounce;
    logic                adv;
    logic                s1_en;
    t_result             core_res;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s1_en         = r_s1_valid && adv;
    assign s_axis_tready = !r_s1_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero     <= ZeroReset;
            r_debounce <= DebounceReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CfgZero:     r_zero     <= i_cfg_wdata;
                CfgDebounce: r_debounce <= i_cfg_wdata[HoldW-1:0];
                default:     r_zero     <= r_zero;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_rows   <= s_axis_tdata[3:0];
            r_s1_sample <= s_axis_tdata[13:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_out_data <= core_res;
        end
    end

    kscal_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s1_en),
        .i_rows     (r_s1_rows),
        .i_sample   (r_s1_sample),
        .i_zero     (r_zero),
        .i_debounce (r_debounce),
        .o_result   (core_res)
    );

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !adv |=> r_s1_valid)
        else $error("input stage lost a request");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_en |=> r_out_valid)
        else $error("processed request not presented");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ===== rtl/kscal_core.sv =====
// kscal_core: scan state, debounce hold, digit capture and calibration arithmetic
// depends on kscal_pkg; state advances once per enabled request
`default_nettype none

module kscal_core #(
    parameter int MAX_DIGITS = 4
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire  [kscal_pkg::RowW-1:0]          i_rows,
    input  wire  [kscal_pkg::SampW-1:0]         i_sample,
    input  wire  [kscal_pkg::ZeroW-1:0]         i_zero,
    input  wire  [kscal_pkg::HoldW-1:0]         i_debounce,
    output kscal_pkg::t_result                  o_result
);
    import kscal_pkg::*;

    localparam int DcW = $clog2(MAX_DIGITS + 1);

    logic [ScanW-1:0]       r_scan, n_scan;
    logic [HoldW-1:0]       r_hold, n_hold;
    logic [ColW-1:0]        r_col, n_col;
    logic                   r_cap, n_cap;
    logic [DcW-1:0]         r_dc, n_dc;
    logic [ValW-1:0]        r_value, n_value;
    logic signed [OffW-1:0] r_off, n_off;

    t_key                   key;
    logic signed [SampW:0]  diff;
    logic signed [SampW:0]  half;
    logic signed [TempW-1:0] temp;

    always_comb begin
        diff = $signed({1'b0, i_sample}) - $signed({1'b0, i_zero});
        half = (diff + $signed({{SampW{1'b0}}, diff[SampW]})) >>> 1;
    end

    always_comb begin
        n_scan  = r_scan + ScanW'(1);
        n_hold  = r_hold;
        n_col   = r_col;
        n_cap   = r_cap;
        n_dc    = r_dc;
        n_value = r_value;
        n_off   = r_off;
        key     = KeyNone;
        if (r_hold == '0) begin
            if (n_scan > ScanW'(2)) begin
                n_scan = '0;
            end
            n_col = ColW'(3'b001 << n_scan[1:0]);
            if (i_rows != '0) begin
                key    = key_lookup(i_rows, n_scan[1:0]);
                n_hold = i_debounce;
            end
            if (key == KeyHash) begin
                n_cap = 1'b1;
                n_dc  = '0;
            end else if (key == KeyStar) begin
                n_cap = 1'b0;
                n_off = OffW'($signed({2'b00, r_value}) - TempW'(half));
            end else if (key <= t_key'(9) && r_cap) begin
                if (r_dc < DcW'(MAX_DIGITS)) begin
                    if (r_dc == '0) begin
                        n_value = ValW'(key);
                    end else begin
                        n_value = ValW'(r_value * 14'd10 + ValW'(key));
                    end
                    n_dc = r_dc + DcW'(1);
                end
            end
        end
        if (n_hold != '0) begin
            n_hold = n_hold - HoldW'(1);
        end
    end

    always_comb begin
        temp = TempW'(n_off) + TempW'(half);
        o_result.column_drive       = n_col;
        o_result.key_code           = key;
        o_result.capture_active     = n_cap;
        o_result.entered_value      = n_value;
        o_result.calibration_offset = n_off[OutOffW-1:0];
        o_result.temperature        = temp[OutOffW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_hold  <= '0;
            r_col   <= '0;
            r_cap   <= 1'b0;
            r_dc    <= '0;
            r_value <= '0;
            r_off   <= '0;
        end else if (i_en) begin
            r_scan  <= n_scan;
            r_hold  <= n_hold;
            r_col   <= n_col;
            r_cap   <= n_cap;
            r_dc    <= n_dc;
            r_value <= n_value;
            r_off   <= n_off;
        end
    end

    a_col_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_col))
        else $error("column drive not one-hot");

    a_dc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= DcW'(MAX_DIGITS))
        else $error("digit count past limit");

    a_hold_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_hold != '0 |=> $stable(r_col) && $stable(r_value))
        else $error("columns or value moved during hold");

    a_hold_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_hold == '0 && i_rows != '0 && i_debounce != '0
        |=> r_hold == $past(i_debounce) - HoldW'(1))
        else $error("hold not reloaded on key");

endmodule

`default_nettype wire

// ===== tb/tb_keypad_scan_calibration_entry_top.sv =====
// self-checking bench for keypad_scan_calibration_entry_top: keypad and calibration predictor,
// directed key entry, then planned and noisy scan ticks under changing settings and back-pressure
// depends on kscal_pkg and keypad_scan_calibration_entry_top
`default_nettype none

module tb_keypad_scan_calibration_entry_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kscal_pkg::*;

    localparam int MaxDigits  = 4;
    localparam int PhaseItems = 316;

    // predicted keypad scan, digit entry and temperature per tick
    class keypad_scoreboard;
        logic [9:0]         zero_count;
        logic [3:0]         debounce;
        logic [4:0]         scan;
        logic [3:0]         hold;
        logic [2:0]         columns;
        logic               capturing;
        logic [2:0]         digits;
        logic [13:0]        value;
        logic signed [15:0] offset;
        t_result            expected_q[$];
        int                 errors;

        function new();
            zero_count = ZeroReset;
            debounce   = DebounceReset;
            scan       = '0;
            hold       = '0;
            columns    = '0;
            capturing  = 1'b0;
            digits     = '0;
            value      = '0;
            offset     = '0;
            errors     = 0;
        endfunction

        function t_key key_at(int r, int c);
            if (r == 3) begin
                if (c == 0) return KeyStar;
                if (c == 1) return t_key'(0);
                return KeyHash;
            end
            return t_key'(3 * r + c + 1);
        endfunction

        function int half_degrees(logic [9:0] sample);
            return (int'(sample) - int'(zero_count)) / 2;
        endfunction

        // column that the next tick will scan, -1 while the hold runs
        function int next_column();
            logic [4:0] s;
            if (hold != 0) return -1;
            s = scan + 5'd1;
            return (s > 5'd2) ? 0 : int'(s);
        endfunction

        function void set_register(t_cfg_idx idx, logic [9:0] val);
            if (idx == CfgZero) zero_count = val;
            else debounce = val[3:0];
        endfunction

        function void note_request(logic [3:0] rows, logic [9:0] sample);
            t_key    k;
            int      r;
            t_result e;
            k = KeyNone;
            scan = scan + 5'd1;
            if (hold == 0) begin
                if (scan > 5'd2) scan = '0;
                columns = 3'(1 << scan);
                r = -1;
                for (int i = 0; i < 4; i++) if (rows[i]) r = i;
                if (r >= 0) begin
                    k = key_at(r, int'(scan));
                    hold = debounce;
                end
                if (k == KeyHash) begin
                    capturing = 1'b1;
                    digits = '0;
                end else if (k == KeyStar) begin
                    capturing = 1'b0;
                    offset = 16'(int'(value) - half_degrees(sample));
                end else if (k <= 4'd9 && capturing && digits < MaxDigits) begin
                    value = (digits == 0) ? 14'(k) : 14'(int'(value) * 10 + int'(k));
                    digits = digits + 3'd1;
                end
            end
            if (hold > 0) hold = hold - 4'd1;
            e.column_drive       = columns;
            e.key_code           = k;
            e.capture_active     = capturing;
            e.entered_value      = value;
            e.calibration_offset = 15'(offset);
            e.temperature        = 15'(int'(offset) + half_degrees(sample));
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] data);
            t_result got;
            t_result e;
            got = t_result'(data[51:0]);
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("column_drive", e.column_drive, got.column_drive);
            compare_field("key_code", e.key_code, got.key_code);
            compare_field("capture_active", e.capture_active, got.capture_active);
            compare_field("entered_value", e.entered_value, got.entered_value);
            compare_field("calibration_offset", int'(e.calibration_offset),
                          int'(got.calibration_offset));
            compare_field("temperature", int'(e.temperature), int'(got.temperature));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // row_lines[3:0], adc_sample[13:4], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // column_drive, key_code, capture_active, entered_value,
                                 // calibration_offset, temperature, zero fill
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [9:0]  i_cfg_wdata;

    keypad_scoreboard sb = new();
    t_key             key_plan[$];
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               stall_left  = 0;

    keypad_scan_calibration_entry_top #(
        .MAX_DIGITS(MaxDigits)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("[keypad_scan_calibration_entry_top] ERROR");
        $finish;
    end

    // result side: random stalls plus one long hold-off when asked
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // rows for the next tick: press the planned key once its column comes round
    function automatic logic [3:0] plan_rows(int noise_pct);
        int col;
        col = sb.next_column();
        if (col < 0 || $urandom_range(99) < noise_pct) return 4'($urandom_range(15));
        if (key_plan.size() == 0) return 4'd0;
        if (key_plan[0] == KeyNone) begin
            void'(key_plan.pop_front());
            return 4'd0;
        end
        for (int r = 0; r < 4; r++) begin
            if (sb.key_at(r, col) == key_plan[0]) begin
                void'(key_plan.pop_front());
                return 4'((1 << r) | ($urandom_range(15) & ((1 << r) - 1)));
            end
        end
        return 4'd0;
    endfunction

    function automatic void plan_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            key_plan.push_back(KeyHash);
            repeat ($urandom_range(6)) key_plan.push_back(t_key'($urandom_range(9)));
            if ($urandom_range(4) != 0) key_plan.push_back(KeyStar);
        end else if (pick < 72) begin
            key_plan.push_back(KeyStar);
        end else if (pick < 84) begin
            repeat ($urandom_range(1, 3)) key_plan.push_back(t_key'($urandom_range(9)));
        end else if (pick < 92) begin
            key_plan.push_back(KeyHash);
            key_plan.push_back(KeyHash);
        end else begin
            repeat ($urandom_range(1, 4)) key_plan.push_back(KeyNone);
        end
    endfunction

    function automatic logic [9:0] pick_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 10'd0;
        if (pick == 1) return 10'd1023;
        return 10'($urandom_range(1023));
    endfunction

    task automatic send_request(input logic [3:0] rows, input logic [9:0] smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, smp, rows};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(rows, smp);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [9:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, val);
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [9:0] zero, input logic [3:0] deb, input int tx_pct,
                             input int rx_pct, input int stall);
        logic [3:0] rows;
        settle();
        write_reg(CfgZero, zero);
        write_reg(CfgDebounce, {6'd0, deb});
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stall_left  = stall;
        for (int i = 0; i < PhaseItems; i++) begin
            if (key_plan.size() == 0) plan_sequence();
            rows = plan_rows(15);
            send_request(rows, pick_sample());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        logic       flip;
        logic [3:0] rows;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CfgZero;
        i_cfg_wdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed entry: repeated hash, overlong 99999, star and digits outside capture
        tx_idle_pct = 27;
        rx_idle_pct = 84;
        write_reg(CfgDebounce, 10'd1);
        key_plan = '{KeyNone, KeyHash, KeyHash, t_key'(9), t_key'(9), t_key'(9), t_key'(9),
                     t_key'(9), KeyStar, t_key'(4), KeyStar, KeyHash, KeyStar, t_key'(0)};
        flip = 1'b0;
        while (key_plan.size() != 0) begin
            rows = plan_rows(0);
            send_request(rows, flip ? 10'd1023 : 10'd0);
            flip = ~flip;
        end
        s_axis_tvalid <= 1'b0;

        run_phase(10'd1023, 4'd15, 27, 84, 0);
        run_phase(10'd0, 4'd1, 27, 84, 0);
        run_phase(10'($urandom_range(1023)), 4'($urandom_range(1, 15)), 84, 27, 0);
        run_phase(10'd94, 4'd10, 84, 27, 0);
        run_phase(10'($urandom_range(1023)), 4'd2, 0, 0, 300);
        run_phase(10'd512, 4'($urandom_range(1, 15)), 0, 0, 0);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[keypad_scan_calibration_entry_top] OK");
        end else begin
            $display("[keypad_scan_calibration_entry_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
